FILE: sv/ersched_pkg.sv
// ----------------------------------------------------------------------------
// ersched_pkg
// Shared codes and types for the elevator request scan scheduler.
// ----------------------------------------------------------------------------
package ersched_pkg;

    typedef logic [2:0] kind_t;
    typedef logic [1:0] floor_in_t;
    typedef logic [1:0] dir_t;

    localparam kind_t KIND_CAB   = 3'd0;
    localparam kind_t KIND_UP    = 3'd1;
    localparam kind_t KIND_DOWN  = 3'd2;
    localparam kind_t KIND_CLEAR = 3'd3;
    localparam kind_t KIND_PICK  = 3'd4;

    localparam dir_t DIR_STOP = 2'd0;
    localparam dir_t DIR_UP   = 2'd1;
    localparam dir_t DIR_DN   = 2'd2;

    // Status of one pass of the floor scanner
    typedef struct packed {
        logic found_above;
        logic found_below;
        logic at_cur;
        logic done;
    } scan_stat_t;

endpackage

FILE: sv/ersched_calls.sv
// ----------------------------------------------------------------------------
// ersched_calls
// Per-floor cab, hall-up and hall-down call flags with one scan read port.
// ----------------------------------------------------------------------------
module ersched_calls #(
    parameter int NUM_FLOORS = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  ersched_pkg::kind_t            kind,
    input  ersched_pkg::floor_in_t        floor,
    input  logic [$clog2(NUM_FLOORS)-1:0] rd_idx,
    output logic                          rd_pend
);
    import ersched_pkg::*;

    localparam int IDX_W = $clog2(NUM_FLOORS);
    localparam int FW    = (IDX_W > 2) ? IDX_W : 2;

    logic [NUM_FLOORS-1:0] cab_reg;
    logic [NUM_FLOORS-1:0] cab_next;
    logic [NUM_FLOORS-1:0] up_reg;
    logic [NUM_FLOORS-1:0] up_next;
    logic [NUM_FLOORS-1:0] down_reg;
    logic [NUM_FLOORS-1:0] down_next;
    logic [NUM_FLOORS-1:0] pend;
    logic [FW-1:0]         floor_ext;
    logic                  ok;
    logic                  is_top;
    logic                  is_bottom;

    assign floor_ext = FW'(floor);
    assign ok        = {1'b0, floor_ext} < (FW+1)'(NUM_FLOORS);
    assign is_top    = floor_ext == FW'(NUM_FLOORS - 1);
    assign is_bottom = floor_ext == '0;

    always_comb
    begin
        cab_next  = cab_reg;
        up_next   = up_reg;
        down_next = down_reg;
        for (int f = 0; f < NUM_FLOORS; f++)
        begin
            if (wr_en && ok && floor_ext == FW'(f))
            begin
                case (kind)
                    KIND_CAB:   cab_next[f] = 1'b1;
                    KIND_UP:    if (!is_top) up_next[f] = 1'b1;
                    KIND_DOWN:  if (!is_bottom) down_next[f] = 1'b1;
                    KIND_CLEAR:
                    begin
                        cab_next[f]  = 1'b0;
                        up_next[f]   = 1'b0;
                        down_next[f] = 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cab_reg  <= '0;
            up_reg   <= '0;
            down_reg <= '0;
        end
        else
        begin
            cab_reg  <= cab_next;
            up_reg   <= up_next;
            down_reg <= down_next;
        end
    end

    assign pend    = cab_reg | up_reg | down_reg;
    assign rd_pend = pend[rd_idx];

endmodule

FILE: sv/ersched_scan.sv
// ----------------------------------------------------------------------------
// ersched_scan
// Walks the floors one per cycle through a single magnitude compare against
// the current floor, tracking the nearest request above and below.
// ----------------------------------------------------------------------------
module ersched_scan #(
    parameter int NUM_FLOORS = 4
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [(($clog2(NUM_FLOORS) > 2) ? $clog2(NUM_FLOORS) : 2)-1:0] cur,
    input  logic                                  rd_pend,
    output logic [$clog2(NUM_FLOORS)-1:0]         rd_idx,
    output logic [$clog2(NUM_FLOORS)-1:0]         above_floor,
    output logic [$clog2(NUM_FLOORS)-1:0]         below_floor,
    output ersched_pkg::scan_stat_t               stat
);
    import ersched_pkg::*;

    localparam int IDX_W = $clog2(NUM_FLOORS);
    localparam int FW    = (IDX_W > 2) ? IDX_W : 2;

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             active_reg;
    logic             active_next;
    logic             done_reg;
    logic             done_next;
    logic             fa_reg;
    logic             fa_next;
    logic             fb_reg;
    logic             fb_next;
    logic             at_reg;
    logic             at_next;
    logic [IDX_W-1:0] above_reg;
    logic [IDX_W-1:0] above_next;
    logic [IDX_W-1:0] below_reg;
    logic [IDX_W-1:0] below_next;
    logic [FW-1:0]    idx_ext;
    logic             gt;
    logic             lt;
    logic             last;

    assign idx_ext = FW'(idx_reg);
    assign gt      = idx_ext > cur;
    assign lt      = idx_ext < cur;
    assign last    = idx_reg == IDX_W'(NUM_FLOORS - 1);

    always_comb
    begin
        idx_next    = idx_reg;
        active_next = active_reg;
        done_next   = 1'b0;
        fa_next     = fa_reg;
        fb_next     = fb_reg;
        at_next     = at_reg;
        above_next  = above_reg;
        below_next  = below_reg;
        if (start)
        begin
            idx_next    = '0;
            active_next = 1'b1;
            fa_next     = 1'b0;
            fb_next     = 1'b0;
            at_next     = 1'b0;
        end
        else if (active_reg)
        begin
            if (rd_pend)
            begin
                // first hit above is nearest; last hit below is nearest
                if (gt && !fa_reg)
                begin
                    fa_next    = 1'b1;
                    above_next = idx_reg;
                end
                if (lt)
                begin
                    fb_next    = 1'b1;
                    below_next = idx_reg;
                end
                if (!gt && !lt)
                    at_next = 1'b1;
            end
            if (last)
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
            else
                idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            fa_reg     <= 1'b0;
            fb_reg     <= 1'b0;
            at_reg     <= 1'b0;
        end
        else
        begin
            idx_reg    <= idx_next;
            active_reg <= active_next;
            done_reg   <= done_next;
            fa_reg     <= fa_next;
            fb_reg     <= fb_next;
            at_reg     <= at_next;
        end
    end

    always_ff @(posedge clk)
    begin
        above_reg <= above_next;
        below_reg <= below_next;
    end

    assign rd_idx           = idx_reg;
    assign above_floor      = above_reg;
    assign below_floor      = below_reg;
    assign stat.found_above = fa_reg;
    assign stat.found_below = fb_reg;
    assign stat.at_cur      = at_reg;
    assign stat.done        = done_reg;

endmodule

FILE: sv/elevator_request_scan_scheduler.sv
// ----------------------------------------------------------------------------
// elevator_request_scan_scheduler
// Holds cab and hall calls per floor and picks the next target by SCAN,
// with a nearest-first radius choice when the car is idle.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+-----------------------------------------
//   request | req_valid | req_stall | kind, floor, direction_in
//   result  | rsp_valid | rsp_stall | target_valid, goal_floor,
//           |           |           | direction_out, requests_above,
//           |           |           | requests_below, requests_any
//
// The accepting edge updates the call flags and starts the scan. The scanner
// then reads one floor per cycle through its single compare, flags done after
// the last floor and then enters the decide step; the result becomes valid and
// req_stall drops in the same cycle, so no new request is taken until then.
// A waiting result holds the decide step but not the scan.
// Reset clears all calls and the held target; no clearing pass is needed.
// ----------------------------------------------------------------------------
module elevator_request_scan_scheduler #(
    parameter int NUM_FLOORS = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  ersched_pkg::kind_t     kind,
    input  ersched_pkg::floor_in_t floor,
    input  ersched_pkg::dir_t      direction_in,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output logic                   target_valid,
    output logic [1:0]             goal_floor,
    output ersched_pkg::dir_t      direction_out,
    output logic                   requests_above,
    output logic                   requests_below,
    output logic                   requests_any
);
    import ersched_pkg::*;

    localparam int IDX_W = $clog2(NUM_FLOORS);
    localparam int FW    = (IDX_W > 2) ? IDX_W : 2;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    kind_t            kind_reg;
    logic [FW-1:0]    cur_reg;
    dir_t             dir_reg;
    logic             held_valid_reg;
    logic             held_valid_next;
    logic [FW-1:0]    held_reg;
    logic [FW-1:0]    held_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    dir_t             dir_out_reg;
    dir_t             dir_out_next;
    logic             above_out_reg;
    logic             below_out_reg;
    logic             any_out_reg;

    logic             accept;
    logic             load;
    logic             rd_pend;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] above_floor;
    logic [IDX_W-1:0] below_floor;
    scan_stat_t       stat;
    logic [FW-1:0]    above_ext;
    logic [FW-1:0]    below_ext;
    logic [FW-1:0]    dist_up;
    logic [FW-1:0]    dist_down;
    logic             any_pend;
    dir_t             dir_echo;

    assign accept = req_valid && !req_stall;
    assign load   = (state_reg == S_DECIDE) && !(rsp_valid_reg && rsp_stall);

    ersched_calls #(
        .NUM_FLOORS (NUM_FLOORS)
    ) u_calls (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .kind    (kind),
        .floor   (floor),
        .rd_idx  (rd_idx),
        .rd_pend (rd_pend)
    );

    ersched_scan #(
        .NUM_FLOORS (NUM_FLOORS)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (accept),
        .cur         (cur_reg),
        .rd_pend     (rd_pend),
        .rd_idx      (rd_idx),
        .above_floor (above_floor),
        .below_floor (below_floor),
        .stat        (stat)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (accept) state_next = S_SCAN;
            S_SCAN:   if (stat.done) state_next = S_DECIDE;
            S_DECIDE: if (load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    assign req_stall = state_reg != S_IDLE;

    assign above_ext = FW'(above_floor);
    assign below_ext = FW'(below_floor);
    assign dist_up   = above_ext - cur_reg;
    assign dist_down = cur_reg - below_ext;
    assign any_pend  = stat.found_above || stat.found_below || stat.at_cur;
    assign dir_echo  = (dir_reg inside {DIR_STOP, DIR_UP, DIR_DN}) ? dir_reg : DIR_STOP;

    always_comb
    begin
        held_valid_next = held_valid_reg;
        held_next       = held_reg;
        dir_out_next    = dir_echo;
        if (kind_reg == KIND_PICK)
        begin
            held_valid_next = 1'b1;
            if (!any_pend)
            begin
                held_valid_next = 1'b0;
                held_next       = '0;
                dir_out_next    = DIR_STOP;
            end
            else
            begin
                case (dir_reg)
                    DIR_UP:
                    begin
                        if (stat.found_above)
                        begin
                            held_next    = above_ext;
                            dir_out_next = DIR_UP;
                        end
                        else if (stat.found_below)
                        begin
                            held_next    = below_ext;
                            dir_out_next = DIR_DN;
                        end
                        else
                        begin
                            held_next    = cur_reg;
                            dir_out_next = DIR_STOP;
                        end
                    end
                    DIR_DN:
                    begin
                        if (stat.found_below)
                        begin
                            held_next    = below_ext;
                            dir_out_next = DIR_DN;
                        end
                        else if (stat.found_above)
                        begin
                            held_next    = above_ext;
                            dir_out_next = DIR_UP;
                        end
                        else
                        begin
                            held_next    = cur_reg;
                            dir_out_next = DIR_STOP;
                        end
                    end
                    default:
                    begin
                        // nearest by radius, upward wins a tie
                        if (stat.at_cur)
                        begin
                            held_next    = cur_reg;
                            dir_out_next = DIR_STOP;
                        end
                        else if (stat.found_above &&
                                 (!stat.found_below || dist_up <= dist_down))
                        begin
                            held_next    = above_ext;
                            dir_out_next = DIR_UP;
                        end
                        else
                        begin
                            held_next    = below_ext;
                            dir_out_next = DIR_DN;
                        end
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (load)
            rsp_valid_next = 1'b1;
        else if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            held_valid_reg <= 1'b0;
            held_reg       <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (load)
            begin
                held_valid_reg <= held_valid_next;
                held_reg       <= held_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            cur_reg  <= FW'(floor);
            dir_reg  <= direction_in;
        end
        if (load)
        begin
            dir_out_reg   <= dir_out_next;
            above_out_reg <= stat.found_above;
            below_out_reg <= stat.found_below;
            any_out_reg   <= any_pend;
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign target_valid   = held_valid_reg;
    assign goal_floor     = held_reg[1:0];
    assign direction_out  = dir_out_reg;
    assign requests_above = above_out_reg;
    assign requests_below = below_out_reg;
    assign requests_any   = any_out_reg;

endmodule
